### src/bf3_pkg.sv
// ----------------------------------------------------------------------------
// bf3_pkg: shared definitions for the 3x3 box filter
// Sample widths, configuration register map, divide-by-nine constants and
// the types passed between the filter lanes and the result merge stage.
// ----------------------------------------------------------------------------
package bf3_pkg;

    // Sample geometry and build-time defaults.
    localparam int SAMPLE_BITS  = 8;
    localparam int IO_CHANNELS  = 3;
    localparam int MAX_WIDTH_DEF = 2048;
    localparam int CHANNELS_DEF  = 3;
    localparam int WINDOW_TAPS   = 9;
    localparam int MIN_WIDTH     = 2;

    // Configuration port.
    localparam int CFG_INDEX_BITS     = 2;
    localparam int CFG_DATA_BITS      = 13;
    localparam int IMAGE_WIDTH_BITS   = 12;
    localparam int CHANNEL_COUNT_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_COUNT = 2'd2;

    localparam logic [IMAGE_WIDTH_BITS-1:0]   IMAGE_WIDTH_RESET   = 12'd2048;
    localparam logic [CHANNEL_COUNT_BITS-1:0] CHANNEL_COUNT_RESET = 2'd3;

    // Window sum of nine samples and its reciprocal multiply. The reciprocal
    // is rounded up, which gives the exact floor for any sum below 32768.
    localparam int SUM_BITS    = SAMPLE_BITS + 4;
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_BITS  = 13;
    localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;
    localparam logic [RECIP_BITS-1:0] RECIP_9 =
        RECIP_BITS'((1 << RECIP_SHIFT) / WINDOW_TAPS + 1);

    // One sample per output channel.
    typedef logic [IO_CHANNELS-1:0][SAMPLE_BITS-1:0] bf3_io_pix_t;

    // Control that travels with a result pair.
    typedef struct packed {
        logic two;   // the item produced two results
        logic eoi;   // the second result is the bottom-right pixel
    } bf3_meta_t;

endpackage

### src/bf3_if.sv
// ----------------------------------------------------------------------------
// bf3_if: stream channels of the 3x3 box filter
// Valid/ready channels for incoming pixel transactions and outgoing results.
// ----------------------------------------------------------------------------
interface bf3_in_if import bf3_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   cmd;
    logic [SAMPLE_BITS-1:0] pix_c0;
    logic [SAMPLE_BITS-1:0] pix_c1;
    logic [SAMPLE_BITS-1:0] pix_c2;

    modport source (output valid, output cmd, output pix_c0, output pix_c1,
                    output pix_c2, input ready);
    modport sink   (input valid, input cmd, input pix_c0, input pix_c1,
                    input pix_c2, output ready);
endinterface

interface bf3_out_if import bf3_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] out_c0;
    logic [SAMPLE_BITS-1:0] out_c1;
    logic [SAMPLE_BITS-1:0] out_c2;
    logic                   end_of_burst;
    logic                   end_of_image;

    modport source (output valid, output out_c0, output out_c1, output out_c2,
                    output end_of_burst, output end_of_image, input ready);
    modport sink   (input valid, input out_c0, input out_c1, input out_c2,
                    input end_of_burst, input end_of_image, output ready);
endinterface

### src/box_filter_3x3_replicate.sv
// ----------------------------------------------------------------------------
// box_filter_3x3_replicate: streaming 3x3 box filter, replicated borders
// Smooths raster-order pixels of up to three 8-bit channels with a 3x3 mean.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on pix_ch, one transaction per clock when the
// result side keeps up; a new pixel is taken while earlier ones are still in
// the pipeline. Output row r comes out while row r+1 arrives: a pixel at
// column 0 gives no result, a pixel at a middle column gives one result and a
// pixel at the last column gives two, so the single result port sends one
// result per clock while the result side is ready, and a row of W pixels
// yields W results. Pixels of the first row give nothing; after the last row
// the host sends image_width flush transactions (cmd = 1), which stand for
// the replicated bottom row and push out the final output row, whose last
// pixel carries end_of_image. A pixel's first result passes the stage 1
// registers, the lane sum registers and the merge slots before it shows.
// Each output sample is the exact floor of the nine-sample sum over nine.
// Channels beyond channel_count (at least one) read as zero. image_height is
// accepted and ignored: flush transactions mark the image end. Configuration
// is to be written only while the block is idle, which it does not enforce.
// ----------------------------------------------------------------------------
module box_filter_3x3_replicate import bf3_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int CHANNELS  = CHANNELS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    bf3_in_if.sink                    pix_ch,
    bf3_out_if.source                 res_ch,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    // At most as many lanes as there are channel ports are ever built.
    localparam int LANES     = (CHANNELS < IO_CHANNELS) ? CHANNELS : IO_CHANNELS;
    localparam int WORD_BITS = LANES * SAMPLE_BITS;
    localparam int COL_BITS  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int LIM_RAW   = $clog2(MAX_WIDTH + 1);
    localparam int LIM_BITS  = (LIM_RAW > IMAGE_WIDTH_BITS) ? LIM_RAW : IMAGE_WIDTH_BITS;

    // Row counter only needs to tell first, second and later rows apart.
    localparam logic [1:0] ROW_FIRST = 2'd0;
    localparam logic [1:0] ROW_LATER = 2'd2;

    typedef logic [LANES-1:0][SAMPLE_BITS-1:0] word_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [IMAGE_WIDTH_BITS-1:0]   image_width_reg;
    logic [CHANNEL_COUNT_BITS-1:0] channel_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg   <= IMAGE_WIDTH_RESET;
            channel_count_reg <= CHANNEL_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:   image_width_reg   <= cfg_data[IMAGE_WIDTH_BITS-1:0];
                REG_IMAGE_HEIGHT:  ;
                REG_CHANNEL_COUNT: channel_count_reg <= cfg_data[CHANNEL_COUNT_BITS-1:0];
                default:           ;
            endcase
        end
    end

    // The row width in use is clamped into the supported range; a column at
    // or past the last one always counts as the last column.
    logic [LIM_BITS-1:0] width_wide, width_eff, last_col;
    logic [1:0]          act_count;

    always_comb
    begin
        width_wide = LIM_BITS'(image_width_reg);
        if (width_wide < LIM_BITS'(MIN_WIDTH))
        begin
            width_eff = LIM_BITS'(MIN_WIDTH);
        end
        else if (width_wide > LIM_BITS'(MAX_WIDTH))
        begin
            width_eff = LIM_BITS'(MAX_WIDTH);
        end
        else
        begin
            width_eff = width_wide;
        end
        last_col = width_eff - LIM_BITS'(1);

        if (channel_count_reg == '0)
        begin
            act_count = 2'd1;
        end
        else if (channel_count_reg > 2'(LANES))
        begin
            act_count = 2'(LANES);
        end
        else
        begin
            act_count = channel_count_reg;
        end
    end

    // ------------------------------------------------------------------
    // Position counters, updated when a pixel transaction is taken
    // ------------------------------------------------------------------
    logic [COL_BITS-1:0] col_reg, col_next;
    logic [1:0]          row_reg, row_next;
    logic                pix_accept, is_last;

    assign pix_accept = pix_ch.valid && pix_ch.ready;
    assign is_last    = LIM_BITS'(col_reg) >= last_col;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (pix_accept)
        begin
            if (is_last)
            begin
                col_next = '0;
                // A flush at the last column closes the image.
                if (pix_ch.cmd)
                begin
                    row_next = ROW_FIRST;
                end
                else if (row_reg != ROW_LATER)
                begin
                    row_next = row_reg + 2'd1;
                end
            end
            else
            begin
                col_next = col_reg + COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= ROW_FIRST;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: line store read data arrives, window columns are formed
    // ------------------------------------------------------------------
    logic                s1_valid_reg;
    logic                s1_cmd_reg, s1_emit_reg, s1_last_reg, s1_col1_reg;
    logic                s1_far_reg;
    logic [COL_BITS-1:0] s1_addr_reg;
    word_t               s1_pix_reg;
    word_t               pix_word;
    bf3_io_pix_t         pix_io;

    assign pix_io[0] = pix_ch.pix_c0;
    assign pix_io[1] = pix_ch.pix_c1;
    assign pix_io[2] = pix_ch.pix_c2;

    for (genvar k = 0; k < LANES; k++)
    begin : g_pix
        assign pix_word[k] = pix_io[k];
    end

    logic s1_leave, s1_free, s2_free, m_ready;
    logic s2_valid_reg, s2_load;

    // The pipeline only moves forward when the next stage has room; items
    // that produce no result leave stage 1 without needing stage 2.
    assign s2_free     = !s2_valid_reg || m_ready;
    assign s1_leave    = s1_valid_reg && (!s1_emit_reg || s2_free);
    assign s1_free     = !s1_valid_reg || s1_leave;
    assign pix_ch.ready = s1_free;
    assign s2_load     = s1_leave && s1_emit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_free)
        begin
            s1_valid_reg <= pix_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            s1_cmd_reg  <= pix_ch.cmd;
            s1_emit_reg <= (row_reg != ROW_FIRST) && (col_reg != '0);
            s1_last_reg <= is_last;
            s1_col1_reg <= (col_reg == COL_BITS'(1));
            s1_far_reg  <= (row_reg == ROW_LATER);
            s1_addr_reg <= col_reg;
            s1_pix_reg  <= pix_word;
        end
    end

    // Two line stores hold the previous row (near) and the one before (far).
    // Each is read when a pixel is taken and written back when that pixel
    // leaves stage 1; consecutive pixels never share a column, so the read
    // always sees the latest write.
    word_t near_word, far_word;
    word_t cur_top, cur_mid, cur_bot;

    bf3_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_near_ram (
        .clk   (clk),
        .we    (s1_leave),
        .waddr (s1_addr_reg),
        .wdata (cur_bot),
        .re    (pix_accept),
        .raddr (col_reg),
        .rdata (near_word)
    );

    bf3_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_far_ram (
        .clk   (clk),
        .we    (s1_leave),
        .waddr (s1_addr_reg),
        .wdata (near_word),
        .re    (pix_accept),
        .raddr (col_reg),
        .rdata (far_word)
    );

    // Top border: while the second row arrives, row 0 is its own upper
    // neighbour. Bottom border: a flush repeats the previous row.
    assign cur_top = s1_far_reg ? far_word : near_word;
    assign cur_mid = near_word;
    assign cur_bot = s1_cmd_reg ? near_word : s1_pix_reg;

    // Window columns: win0 is the column just before the current one, win1
    // the one before that.
    word_t win0_reg [3];
    word_t win1_reg [3];
    word_t left_col [3];
    word_t right_col [3];

    assign right_col[0] = cur_top;
    assign right_col[1] = cur_mid;
    assign right_col[2] = cur_bot;

    // Left border: at output column 0 the left column is the centre itself.
    for (genvar r = 0; r < 3; r++)
    begin : g_left
        assign left_col[r] = s1_col1_reg ? win0_reg[r] : win1_reg[r];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win0_reg[r] <= '0;
                win1_reg[r] <= '0;
            end
        end
        else if (s1_leave)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win1_reg[r] <= win0_reg[r];
                win0_reg[r] <= right_col[r];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: per-channel lanes hold the window sums of a result pair
    // ------------------------------------------------------------------
    bf3_meta_t   s2_meta_reg;
    bf3_io_pix_t quot_a_io, quot_b_io;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_free)
        begin
            s2_valid_reg <= s2_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            s2_meta_reg.two <= s1_last_reg;
            s2_meta_reg.eoi <= s1_cmd_reg && s1_last_reg;
        end
    end

    // The second result of a pair (last column) uses the window shifted one
    // column right with the right border replicated; each lane forms both.
    for (genvar k = 0; k < IO_CHANNELS; k++)
    begin : g_lane
        if (k < LANES)
        begin : g_on
            logic [2:0][SAMPLE_BITS-1:0] lane_l, lane_c, lane_r;

            for (genvar r = 0; r < 3; r++)
            begin : g_tap
                assign lane_l[r] = left_col[r][k];
                assign lane_c[r] = win0_reg[r][k];
                assign lane_r[r] = right_col[r][k];
            end

            bf3_lane u_lane (
                .clk    (clk),
                .load   (s2_load),
                .active (2'(k) < act_count),
                .left   (lane_l),
                .centre (lane_c),
                .right  (lane_r),
                .quot_a (quot_a_io[k]),
                .quot_b (quot_b_io[k])
            );
        end
        else
        begin : g_off
            assign quot_a_io[k] = '0;
            assign quot_b_io[k] = '0;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: merge the lanes and send results
    // ------------------------------------------------------------------
    bf3_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s2_valid_reg),
        .in_ready (m_ready),
        .meta     (s2_meta_reg),
        .quot_a   (quot_a_io),
        .quot_b   (quot_b_io),
        .res_ch   (res_ch)
    );

endmodule

### src/bf3_ram.sv
// ----------------------------------------------------------------------------
// bf3_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bf3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/bf3_lane.sv
// ----------------------------------------------------------------------------
// bf3_lane: one channel of the 3x3 box filter
// Sums the two windows of a result pair, registers the sums and divides
// each by nine with a reciprocal multiply.
// ----------------------------------------------------------------------------
module bf3_lane import bf3_pkg::*; (
    input  logic                        clk,
    input  logic                        load,
    input  logic                        active,
    input  logic [2:0][SAMPLE_BITS-1:0] left,
    input  logic [2:0][SAMPLE_BITS-1:0] centre,
    input  logic [2:0][SAMPLE_BITS-1:0] right,
    output logic [SAMPLE_BITS-1:0]      quot_a,
    output logic [SAMPLE_BITS-1:0]      quot_b
);

    logic [SUM_BITS-1:0]  col_l, col_c, col_r;
    logic [SUM_BITS-1:0]  sum_a, sum_b;
    logic [SUM_BITS-1:0]  sum_a_reg, sum_b_reg;
    logic [PROD_BITS-1:0] prod_a, prod_b;

    always_comb
    begin
        col_l = SUM_BITS'(left[0])   + SUM_BITS'(left[1])   + SUM_BITS'(left[2]);
        col_c = SUM_BITS'(centre[0]) + SUM_BITS'(centre[1]) + SUM_BITS'(centre[2]);
        col_r = SUM_BITS'(right[0])  + SUM_BITS'(right[1])  + SUM_BITS'(right[2]);
        sum_a = col_l + col_c + col_r;
        // The second window of a pair repeats the right column.
        sum_b = col_c + (col_r << 1);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sum_a_reg <= active ? sum_a : '0;
            sum_b_reg <= active ? sum_b : '0;
        end
    end

    assign prod_a = PROD_BITS'(sum_a_reg) * PROD_BITS'(RECIP_9);
    assign prod_b = PROD_BITS'(sum_b_reg) * PROD_BITS'(RECIP_9);
    assign quot_a = prod_a[RECIP_SHIFT +: SAMPLE_BITS];
    assign quot_b = prod_b[RECIP_SHIFT +: SAMPLE_BITS];

endmodule

### src/bf3_merge.sv
// ----------------------------------------------------------------------------
// bf3_merge: result merge and output stage
// Collects the lane quotients of one item into a result pair and sends its
// one or two results out one transaction at a time.
// ----------------------------------------------------------------------------
module bf3_merge import bf3_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  bf3_meta_t    meta,
    input  bf3_io_pix_t  quot_a,
    input  bf3_io_pix_t  quot_b,
    bf3_out_if.source    res_ch
);

    localparam logic [1:0] LEFT_NONE = 2'd0;
    localparam logic [1:0] LEFT_ONE  = 2'd1;
    localparam logic [1:0] LEFT_TWO  = 2'd2;

    logic [1:0]  left_reg, left_next;
    logic        sel_reg, sel_next;
    logic        eoi_reg;
    bf3_io_pix_t slot0_reg, slot1_reg, shown;
    logic        take, load;

    assign take     = res_ch.valid && res_ch.ready;
    assign in_ready = (left_reg == LEFT_NONE) || ((left_reg == LEFT_ONE) && res_ch.ready);
    assign load     = in_valid && in_ready;

    always_comb
    begin
        left_next = left_reg;
        sel_next  = sel_reg;
        if (load)
        begin
            left_next = meta.two ? LEFT_TWO : LEFT_ONE;
            sel_next  = 1'b0;
        end
        else if (take)
        begin
            left_next = left_reg - LEFT_ONE;
            sel_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= LEFT_NONE;
            sel_reg  <= 1'b0;
        end
        else
        begin
            left_reg <= left_next;
            sel_reg  <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot0_reg <= quot_a;
            slot1_reg <= quot_b;
            eoi_reg   <= meta.two && meta.eoi;
        end
    end

    assign shown               = sel_reg ? slot1_reg : slot0_reg;
    assign res_ch.valid        = (left_reg != LEFT_NONE);
    assign res_ch.out_c0       = shown[0];
    assign res_ch.out_c1       = shown[1];
    assign res_ch.out_c2       = shown[2];
    assign res_ch.end_of_burst = (left_reg == LEFT_ONE);
    assign res_ch.end_of_image = (left_reg == LEFT_ONE) && eoi_reg;

endmodule

### src/bf3_checker.sv
// ----------------------------------------------------------------------------
// bf3_checker: port-level assertions for the 3x3 box filter
// Watches the result channel of the top level and is bound to it.
// ----------------------------------------------------------------------------
module bf3_checker import bf3_pkg::*; (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   res_valid,
    input logic                   res_ready,
    input logic [SAMPLE_BITS-1:0] res_c0,
    input logic [SAMPLE_BITS-1:0] res_c1,
    input logic [SAMPLE_BITS-1:0] res_c2,
    input logic                   res_eob,
    input logic                   res_eoi
);

    // The image end is always the last result of its transaction.
    a_eoi_closes_burst: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_eoi |-> res_eob)
        else $error("end_of_image without end_of_burst");

    // The second result of a pair is already buffered when the first leaves.
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !res_eob |=> res_valid)
        else $error("second result of a pair missing");

    // A stalled result holds.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_c0) && $stable(res_c1)
            && $stable(res_c2) && $stable(res_eob) && $stable(res_eoi))
        else $error("stalled result changed");

endmodule

bind box_filter_3x3_replicate bf3_checker u_bf3_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_ch.valid),
    .res_ready (res_ch.ready),
    .res_c0    (res_ch.out_c0),
    .res_c1    (res_ch.out_c1),
    .res_c2    (res_ch.out_c2),
    .res_eob   (res_ch.end_of_burst),
    .res_eoi   (res_ch.end_of_image)
);
